FILE: design/lnsd_pkg.sv
`default_nettype none

package lnsd_pkg;

    // Item kinds carried in the mode field
    localparam logic [2:0] MODE_NODE  = 3'd0;
    localparam logic [2:0] MODE_RIGHT = 3'd1;
    localparam logic [2:0] MODE_LEFT  = 3'd2;
    localparam logic [2:0] MODE_DOWN  = 3'd3;
    localparam logic [2:0] MODE_UP    = 3'd4;

    // Steps of the shared root/divide unit: one quotient or root bit per step
    localparam int DU_STEPS = 33;

    localparam logic [31:0] MASS_ONE = 32'h0001_0000;

    localparam logic signed [47:0] S48_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] S48_MIN = 48'sh8000_0000_0000;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQ0,
        ST_SQ1,
        ST_SQ2,
        ST_SQS,
        ST_SQW,
        ST_DXW,
        ST_DYW,
        ST_TSEL,
        ST_RM,
        ST_RV,
        ST_TM0,
        ST_TM1,
        ST_TM2,
        ST_TSAT,
        ST_TADD,
        ST_MXS,
        ST_MXW,
        ST_MYS,
        ST_MYW,
        ST_OUT
    } t_state;

    typedef enum logic {
        DU_DIV,
        DU_SQRT
    } t_du_op;

    typedef struct packed {
        logic        start;
        t_du_op      op;
        logic [65:0] arg;
        logic [32:0] den;
    } t_du_req;

    typedef struct packed {
        logic        done;
        logic        ovf;
        logic [32:0] res;
    } t_du_rsp;

    function automatic logic [31:0] f_mag33(input logic signed [32:0] v);
        logic [32:0] n;
        n = 33'(-v);
        return v[32] ? n[31:0] : v[31:0];
    endfunction

    function automatic logic [31:0] f_mag32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : v;
    endfunction

    function automatic logic [47:0] f_mag48(input logic signed [47:0] v);
        return v[47] ? 48'(-v) : v;
    endfunction

    function automatic logic signed [31:0] f_accel(input logic [32:0] q, input logic ovf,
                                                   input logic neg);
        logic signed [31:0] r;
        logic [32:0]        nq;
        nq = 33'(-q);
        if (ovf) begin
            r = neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else if (neg) begin
            r = (q > 33'h0_8000_0000) ? 32'sh8000_0000 : nq[31:0];
        end else begin
            r = (q > 33'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : q[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: design/lnsd_divsqrt.sv
`default_nettype none

module lnsd_divsqrt import lnsd_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_du_req i_req,
    output t_du_rsp      o_rsp
);

    localparam int CW = $clog2(DU_STEPS + 1);

    logic          r_busy;
    logic          r_done;
    t_du_op        r_op;
    logic [CW-1:0] r_cnt;
    logic [35:0]   r_rem;
    logic [32:0]   r_res;
    logic [65:0]   r_sh;
    logic [32:0]   r_den;
    logic          r_ovf;

    logic [35:0] cand;
    logic [35:0] trial;
    logic        ge;
    logic [35:0] n_rem;

    // Restoring step: two radicand bits per root bit, one dividend bit per quotient bit
    always_comb begin
        if (r_op == DU_SQRT) begin
            cand  = {r_rem[33:0], r_sh[65:64]};
            trial = {1'b0, r_res, 2'b01};
        end else begin
            cand  = {r_rem[34:0], r_sh[65]};
            trial = {3'b000, r_den};
        end
        ge    = (cand >= trial);
        n_rem = ge ? (cand - trial) : cand;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DU_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op  <= i_req.op;
            r_res <= '0;
            r_den <= i_req.den;
            if (i_req.op == DU_SQRT) begin
                r_rem <= '0;
                r_sh  <= i_req.arg;
                r_ovf <= 1'b0;
            end else begin
                r_rem <= {5'b0, i_req.arg[63:33]};
                r_sh  <= {i_req.arg[32:0], 33'b0};
                r_ovf <= ({2'b00, i_req.arg[63:33]} >= i_req.den);
            end
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_res <= {r_res[31:0], ge};
            r_sh  <= (r_op == DU_SQRT) ? {r_sh[63:0], 2'b00} : {r_sh[64:0], 1'b0};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.ovf  = r_ovf;
    assign o_rsp.res  = r_res;

endmodule

`default_nettype wire

FILE: design/lattice_node_spring_derivative_top.sv
`default_nettype none

// Derivative of one node of a 2D mass-spring lattice, Q16.16 throughout. Send a node
// word (mode 0) and then the right, left, down and up neighbour words; after the up word
// one result word gives the node velocity and the saturated force/mass. A node word is
// only stored, and the input stays ready. A neighbour word holds the input through the
// accept, the two squares and the start of the root, then the root of the spring length
// and the two projections on the shared 33-step root/divide unit (one root or quotient
// bit per cycle). Its force terms follow on the single shared 32x32 multiplier, which
// builds each term in two partial products: a damping or spring term is selected,
// multiplied, summed, saturated and added; a random term first forms the product of
// random value and velocity; a gated-off term is skipped at selection. The up word adds
// the two mass divisions and the result load; a force sum of zero skips its division.
// The input is not ready while a word is in work. The result is held in an output
// register, so the next word is taken while the result waits; a further result stalls
// only until the waiting one is taken. The coupling register is written at any time
// through its own channel, which is always ready.

module lattice_node_spring_derivative_top import lnsd_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic               i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [2:0]         i_mode,
    input  wire logic signed [31:0] i_pos_x,
    input  wire logic signed [31:0] i_pos_y,
    input  wire logic signed [31:0] i_vel_x,
    input  wire logic signed [31:0] i_vel_y,
    input  wire logic signed [31:0] i_rand_x,
    input  wire logic signed [31:0] i_rand_y,
    input  wire logic [31:0]        i_stiffness,
    input  wire logic [31:0]        i_damping,
    input  wire logic [31:0]        i_mass,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [31:0]      o_deriv_pos_x,
    output logic signed [31:0]      o_accel_x,
    output logic signed [31:0]      o_deriv_pos_y,
    output logic signed [31:0]      o_accel_y
);

    // Force terms, taken in this order for every neighbour word
    localparam logic [2:0] TRM_RAND_X   = 3'd0;
    localparam logic [2:0] TRM_DAMP_X   = 3'd1;
    localparam logic [2:0] TRM_SPRING_X = 3'd2;
    localparam logic [2:0] TRM_RAND_Y   = 3'd3;
    localparam logic [2:0] TRM_DAMP_Y   = 3'd4;
    localparam logic [2:0] TRM_SPRING_Y = 3'd5;

    t_state r_state, n_state;

    logic               r_tc, n_tc;
    logic signed [31:0] r_npx, n_npx, r_npy, n_npy;
    logic signed [31:0] r_nvx, n_nvx, r_nvy, n_nvy;
    logic signed [31:0] r_nrx, n_nrx, r_nry, n_nry;
    logic [31:0]        r_nmass, n_nmass;
    logic signed [47:0] r_fx, n_fx, r_fy, n_fy;

    logic [2:0]         r_mode, n_mode;
    logic signed [32:0] r_sx, n_sx, r_sy, n_sy;
    logic [31:0]        r_dvx, n_dvx, r_dvy, n_dvy;
    logic [31:0]        r_k, n_k, r_g, n_g;
    logic [32:0]        r_len, n_len;
    logic [31:0]        r_pxm, n_pxm, r_pym, n_pym;
    logic               r_pxn, n_pxn, r_pyn, n_pyn;
    logic [63:0]        r_prod, n_prod;
    logic [79:0]        r_acc, n_acc;
    logic [47:0]        r_val, n_val;
    logic               r_tneg, n_tneg;
    logic [2:0]         r_term, n_term;
    logic signed [47:0] r_t, n_t;
    logic signed [31:0] r_qx, n_qx, r_qy, n_qy;

    logic               r_ovalid, n_ovalid;
    logic signed [31:0] r_odx, n_odx, r_oax, n_oax, r_ody, n_ody, r_oay, n_oay;

    t_du_req du_req;
    t_du_rsp du_rsp;

    lnsd_divsqrt u_du (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (du_req),
        .o_rsp   (du_rsp)
    );

    logic        in_acc;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;

    // Term properties for the current term index
    logic        t_en, t_rand, t_negate, t_vneg, t_ydir;
    logic [47:0] t_valv;
    logic [31:0] t_coef;

    // Projection and saturation helpers
    logic [31:0] s_mag;
    logic        s_neg;
    logic [31:0] p_mag;
    logic        p_neg;
    logic [63:0] sh;
    logic signed [47:0] sum_sel;
    logic signed [48:0] sum_w;
    logic signed [47:0] sum_sat;
    logic [47:0] f_mag;
    logic [31:0] sx_mag, sy_mag;
    logic signed [32:0] dvx_w, dvy_w;
    logic        last_term;
    t_state      after_term;

    assign in_acc      = i_in_valid && o_in_ready;
    assign mul_p       = mul_a * mul_b;
    assign sx_mag      = f_mag33(r_sx);
    assign sy_mag      = f_mag33(r_sy);
    assign dvx_w       = {r_nvx[31], r_nvx} - {i_vel_x[31], i_vel_x};
    assign dvy_w       = {r_nvy[31], r_nvy} - {i_vel_y[31], i_vel_y};
    assign last_term   = (r_term == TRM_SPRING_Y);
    assign after_term  = last_term ? ((r_mode == MODE_UP) ? ST_MXS : ST_IDLE) : ST_TSEL;

    always_comb begin
        t_en     = 1'b0;
        t_rand   = 1'b0;
        t_negate = 1'b0;
        t_vneg   = 1'b0;
        t_ydir   = 1'b0;
        t_valv   = '0;
        t_coef   = r_g;
        unique case (r_term)
            TRM_RAND_X: begin
                t_en   = (r_mode == MODE_RIGHT);
                t_rand = 1'b1;
            end
            TRM_DAMP_X: begin
                t_en     = 1'b1;
                t_negate = 1'b1;
                t_valv   = {16'b0, r_dvx};
            end
            TRM_SPRING_X: begin
                t_en     = (r_mode == MODE_RIGHT) || (r_mode == MODE_LEFT) || r_tc;
                t_negate = (r_mode != MODE_RIGHT);
                t_vneg   = r_pxn;
                t_valv   = {16'b0, r_pxm};
                t_coef   = r_k;
            end
            TRM_RAND_Y: begin
                t_en   = (r_mode == MODE_RIGHT);
                t_rand = 1'b1;
                t_ydir = 1'b1;
            end
            TRM_DAMP_Y: begin
                t_en     = 1'b1;
                t_negate = 1'b1;
                t_valv   = {16'b0, r_dvy};
                t_ydir   = 1'b1;
            end
            TRM_SPRING_Y: begin
                t_en     = (r_mode == MODE_DOWN) || (r_mode == MODE_UP) || r_tc;
                t_negate = (r_mode != MODE_UP);
                t_vneg   = r_pyn;
                t_valv   = {16'b0, r_pym};
                t_coef   = r_k;
                t_ydir   = 1'b1;
            end
            default: begin
                t_en = 1'b0;
            end
        endcase
    end

    // Projection p = s - sgn(s)*q; the spring length is never below |s|
    always_comb begin
        s_mag = (r_state == ST_DXW) ? sx_mag : sy_mag;
        s_neg = (r_state == ST_DXW) ? r_sx[32] : r_sy[32];
        if (r_len == '0) begin
            p_mag = '0;
            p_neg = 1'b0;
        end else if ({1'b0, s_mag} >= du_rsp.res) begin
            p_mag = s_mag - du_rsp.res[31:0];
            p_neg = s_neg;
        end else begin
            p_mag = du_rsp.res[31:0] - s_mag;
            p_neg = !s_neg;
        end
    end

    // Saturating accumulate of one term
    always_comb begin
        sh      = r_acc[79:16];
        sum_sel = t_ydir ? r_fy : r_fx;
        sum_w   = {sum_sel[47], sum_sel} + {r_t[47], r_t};
        if (sum_w[48] != sum_w[47]) begin
            sum_sat = sum_w[48] ? S48_MIN : S48_MAX;
        end else begin
            sum_sat = sum_w[47:0];
        end
        f_mag = f_mag48((r_state == ST_MXS) ? r_fx : r_fy);
    end

    always_comb begin
        n_state  = r_state;
        n_tc     = r_tc;
        n_npx    = r_npx;
        n_npy    = r_npy;
        n_nvx    = r_nvx;
        n_nvy    = r_nvy;
        n_nrx    = r_nrx;
        n_nry    = r_nry;
        n_nmass  = r_nmass;
        n_fx     = r_fx;
        n_fy     = r_fy;
        n_mode   = r_mode;
        n_sx     = r_sx;
        n_sy     = r_sy;
        n_dvx    = r_dvx;
        n_dvy    = r_dvy;
        n_k      = r_k;
        n_g      = r_g;
        n_len    = r_len;
        n_pxm    = r_pxm;
        n_pxn    = r_pxn;
        n_pym    = r_pym;
        n_pyn    = r_pyn;
        n_prod   = r_prod;
        n_acc    = r_acc;
        n_val    = r_val;
        n_tneg   = r_tneg;
        n_term   = r_term;
        n_t      = r_t;
        n_qx     = r_qx;
        n_qy     = r_qy;
        n_ovalid = r_ovalid;
        n_odx    = r_odx;
        n_oax    = r_oax;
        n_ody    = r_ody;
        n_oay    = r_oay;
        mul_a    = '0;
        mul_b    = '0;
        du_req.start = 1'b0;
        du_req.op    = DU_DIV;
        du_req.arg   = '0;
        du_req.den   = '0;
        o_in_ready   = (r_state == ST_IDLE);

        if (i_cfg_valid) begin
            n_tc = i_cfg_data;
        end
        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    priority if (i_mode == MODE_NODE) begin
                        n_npx   = i_pos_x;
                        n_npy   = i_pos_y;
                        n_nvx   = i_vel_x;
                        n_nvy   = i_vel_y;
                        n_nrx   = i_rand_x;
                        n_nry   = i_rand_y;
                        n_nmass = i_mass;
                        n_fx    = '0;
                        n_fy    = '0;
                    end else if (i_mode <= MODE_UP) begin
                        n_mode = i_mode;
                        n_sx   = (i_mode == MODE_RIGHT)
                               ? ({i_pos_x[31], i_pos_x} - {r_npx[31], r_npx})
                               : ({r_npx[31], r_npx} - {i_pos_x[31], i_pos_x});
                        n_sy   = (i_mode == MODE_UP)
                               ? ({i_pos_y[31], i_pos_y} - {r_npy[31], r_npy})
                               : ({r_npy[31], r_npy} - {i_pos_y[31], i_pos_y});
                        n_dvx  = f_mag33(dvx_w);
                        n_dvy  = f_mag33(dvy_w);
                        n_k    = i_stiffness;
                        n_g    = i_damping;
                        n_state = ST_SQ0;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_SQ0: begin
                mul_a   = sx_mag;
                mul_b   = sx_mag;
                n_prod  = mul_p;
                n_state = ST_SQ1;
            end
            ST_SQ1: begin
                n_acc   = 80'(r_prod);
                mul_a   = sy_mag;
                mul_b   = sy_mag;
                n_prod  = mul_p;
                n_state = ST_SQ2;
            end
            ST_SQ2: begin
                n_acc   = r_acc + 80'(r_prod);
                n_state = ST_SQS;
            end
            ST_SQS: begin
                du_req.start = 1'b1;
                du_req.op    = DU_SQRT;
                du_req.arg   = r_acc[65:0];
                n_state      = ST_SQW;
            end
            ST_SQW: begin
                if (du_rsp.done) begin
                    n_len        = du_rsp.res;
                    du_req.start = 1'b1;
                    du_req.arg   = {18'b0, sx_mag, 16'b0};
                    du_req.den   = du_rsp.res;
                    n_state      = ST_DXW;
                end
            end
            ST_DXW: begin
                if (du_rsp.done) begin
                    n_pxm        = p_mag;
                    n_pxn        = p_neg;
                    du_req.start = 1'b1;
                    du_req.arg   = {18'b0, sy_mag, 16'b0};
                    du_req.den   = r_len;
                    n_state      = ST_DYW;
                end
            end
            ST_DYW: begin
                if (du_rsp.done) begin
                    n_pym   = p_mag;
                    n_pyn   = p_neg;
                    n_term  = TRM_RAND_X;
                    n_state = ST_TSEL;
                end
            end
            ST_TSEL: begin
                if (!t_en) begin
                    n_term  = r_term + 3'd1;
                    n_state = after_term;
                end else begin
                    n_tneg  = t_vneg ^ t_negate;
                    n_val   = t_valv;
                    n_state = t_rand ? ST_RM : ST_TM0;
                end
            end
            ST_RM: begin
                mul_a   = t_ydir ? f_mag32(r_nry) : f_mag32(r_nrx);
                mul_b   = t_ydir ? f_mag32(r_nvy) : f_mag32(r_nvx);
                n_prod  = mul_p;
                n_state = ST_RV;
            end
            ST_RV: begin
                n_val   = r_prod[63:16];
                n_state = ST_TM0;
            end
            ST_TM0: begin
                mul_a   = t_coef;
                mul_b   = r_val[31:0];
                n_prod  = mul_p;
                n_state = ST_TM1;
            end
            ST_TM1: begin
                n_acc   = 80'(r_prod);
                mul_a   = t_coef;
                mul_b   = {16'b0, r_val[47:32]};
                n_prod  = mul_p;
                n_state = ST_TM2;
            end
            ST_TM2: begin
                n_acc   = r_acc + {r_prod[47:0], 32'b0};
                n_state = ST_TSAT;
            end
            ST_TSAT: begin
                if (r_tneg) begin
                    n_t = (sh > 64'h0000_8000_0000_0000) ? S48_MIN : 48'(-sh);
                end else begin
                    n_t = (sh > 64'h0000_7FFF_FFFF_FFFF) ? S48_MAX : sh[47:0];
                end
                n_state = ST_TADD;
            end
            ST_TADD: begin
                if (t_ydir) begin
                    n_fy = sum_sat;
                end else begin
                    n_fx = sum_sat;
                end
                n_term  = r_term + 3'd1;
                n_state = after_term;
            end
            ST_MXS: begin
                if (f_mag == '0) begin
                    n_qx    = '0;
                    n_state = ST_MYS;
                end else begin
                    du_req.start = 1'b1;
                    du_req.arg   = {2'b0, f_mag, 16'b0};
                    du_req.den   = {1'b0, r_nmass};
                    n_state      = ST_MXW;
                end
            end
            ST_MXW: begin
                if (du_rsp.done) begin
                    n_qx    = f_accel(du_rsp.res, du_rsp.ovf, r_fx[47]);
                    n_state = ST_MYS;
                end
            end
            ST_MYS: begin
                if (f_mag == '0) begin
                    n_qy    = '0;
                    n_state = ST_OUT;
                end else begin
                    du_req.start = 1'b1;
                    du_req.arg   = {2'b0, f_mag, 16'b0};
                    du_req.den   = {1'b0, r_nmass};
                    n_state      = ST_MYW;
                end
            end
            ST_MYW: begin
                if (du_rsp.done) begin
                    n_qy    = f_accel(du_rsp.res, du_rsp.ovf, r_fy[47]);
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                // hold until the output register is free, then load the word
                if (!r_ovalid || i_out_ready) begin
                    n_ovalid = 1'b1;
                    n_odx    = r_nvx;
                    n_oax    = r_qx;
                    n_ody    = r_nvy;
                    n_oay    = r_qy;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_tc     <= 1'b1;
            r_npx    <= '0;
            r_npy    <= '0;
            r_nvx    <= '0;
            r_nvy    <= '0;
            r_nrx    <= '0;
            r_nry    <= '0;
            r_nmass  <= MASS_ONE;
            r_fx     <= '0;
            r_fy     <= '0;
            r_ovalid <= 1'b0;
            r_term   <= '0;
        end else begin
            r_state  <= n_state;
            r_tc     <= n_tc;
            r_npx    <= n_npx;
            r_npy    <= n_npy;
            r_nvx    <= n_nvx;
            r_nvy    <= n_nvy;
            r_nrx    <= n_nrx;
            r_nry    <= n_nry;
            r_nmass  <= n_nmass;
            r_fx     <= n_fx;
            r_fy     <= n_fy;
            r_ovalid <= n_ovalid;
            r_term   <= n_term;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode <= n_mode;
        r_sx   <= n_sx;
        r_sy   <= n_sy;
        r_dvx  <= n_dvx;
        r_dvy  <= n_dvy;
        r_k    <= n_k;
        r_g    <= n_g;
        r_len  <= n_len;
        r_pxm  <= n_pxm;
        r_pxn  <= n_pxn;
        r_pym  <= n_pym;
        r_pyn  <= n_pyn;
        r_prod <= n_prod;
        r_acc  <= n_acc;
        r_val  <= n_val;
        r_tneg <= n_tneg;
        r_t    <= n_t;
        r_qx   <= n_qx;
        r_qy   <= n_qy;
        r_odx  <= n_odx;
        r_oax  <= n_oax;
        r_ody  <= n_ody;
        r_oay  <= n_oay;
    end

    assign o_cfg_ready   = 1'b1;
    assign o_out_valid   = r_ovalid;
    assign o_deriv_pos_x = r_odx;
    assign o_accel_x     = r_oax;
    assign o_deriv_pos_y = r_ody;
    assign o_accel_y     = r_oay;

    // Root/divide results arrive only while the sequencer waits for them
    a_du_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        du_rsp.done |-> (r_state == ST_SQW || r_state == ST_DXW || r_state == ST_DYW ||
                         r_state == ST_MXW || r_state == ST_MYW))
        else $error("root/divide result with no waiting step");

    // A node word clears both force sums
    a_node_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_mode == MODE_NODE) |=> (r_fx == '0 && r_fy == '0))
        else $error("force sums not cleared by node word");

    // A neighbour word blocks the input while it is worked
    a_nb_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_mode != MODE_NODE && i_mode <= MODE_UP) |=> !o_in_ready)
        else $error("input ready during neighbour work");

endmodule

`default_nettype wire

FILE: tb/tb_lattice_node_spring_derivative_top.sv
`timescale 1ns / 1ps

module tb_lattice_node_spring_derivative_top;
    import lnsd_pkg::*;

    // One neighbour or node word as it is offered on the input channel
    typedef struct {
        logic [2:0]         mode;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] rand_x;
        logic signed [31:0] rand_y;
        logic [31:0]        stiffness;
        logic [31:0]        damping;
        logic [31:0]        mass;
    } word_t;

    typedef struct {
        logic signed [31:0] deriv_pos_x;
        logic signed [31:0] accel_x;
        logic signed [31:0] deriv_pos_y;
        logic signed [31:0] accel_y;
    } deriv_t;

    // Directed row: typed expectation used only when fixed_exp is set
    typedef struct {
        word_t  w;
        bit     fixed_exp;
        deriv_t d;
    } row_t;

    localparam int WATCHDOG_LIMIT = 10000;
    localparam int SETTLE_CYCLES  = 400;
    localparam int HOLDOFF_CYCLES = 3000;
    localparam int PHASE_WORDS    = 425;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic               i_cfg_data;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [2:0]         i_mode;
    logic signed [31:0] i_pos_x;
    logic signed [31:0] i_pos_y;
    logic signed [31:0] i_vel_x;
    logic signed [31:0] i_vel_y;
    logic signed [31:0] i_rand_x;
    logic signed [31:0] i_rand_y;
    logic [31:0]        i_stiffness;
    logic [31:0]        i_damping;
    logic [31:0]        i_mass;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [31:0] o_deriv_pos_x;
    logic signed [31:0] o_accel_x;
    logic signed [31:0] o_deriv_pos_y;
    logic signed [31:0] o_accel_y;

    lattice_node_spring_derivative_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_mode        (i_mode),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_vel_x       (i_vel_x),
        .i_vel_y       (i_vel_y),
        .i_rand_x      (i_rand_x),
        .i_rand_y      (i_rand_y),
        .i_stiffness   (i_stiffness),
        .i_damping     (i_damping),
        .i_mass        (i_mass),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_deriv_pos_x (o_deriv_pos_x),
        .o_accel_x     (o_accel_x),
        .o_deriv_pos_y (o_deriv_pos_y),
        .o_accel_y     (o_accel_y)
    );

    // Predictor state: stored node, running force sums and the coupling bit
    longint      node_px, node_py, node_vx, node_vy, node_rx, node_ry;
    logic [31:0] node_m;
    longint      force_x, force_y;
    bit          coupling;

    deriv_t      deriv_q[$];
    row_t        dir_rows[$];
    int          fails;
    int          cycle_cnt;
    bit          hold_req;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] mag(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    // Floor of the spring length, one root bit at a time
    function automatic logic [63:0] spring_len(input logic [63:0] ax, input logic [63:0] ay);
        logic [127:0] n;
        logic [127:0] r;
        logic [127:0] c;
        n = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay);
        r = '0;
        for (int b = 32; b >= 0; b--) begin
            c = r | (128'd1 << b);
            if (c * c <= n) r = c;
        end
        return r[63:0];
    endfunction

    // s*(L-1)/L, with the quotient truncated on the magnitude
    function automatic longint project(input longint s, input logic [63:0] len);
        logic [63:0] q;
        if (len == 0) return 0;
        q = (mag(s) << 16) / len;
        return s < 0 ? s + longint'(q) : s - longint'(q);
    endfunction

    function automatic longint sat48(input longint v);
        if (v > longint'(S48_MAX)) return longint'(S48_MAX);
        if (v < longint'(S48_MIN)) return longint'(S48_MIN);
        return v;
    endfunction

    // Add (coef*|val|)>>16 with the sign of val, flipped when negate is set
    function automatic longint add_force(input longint acc, input logic [63:0] coef,
                                         input longint val, input bit negate);
        logic [127:0] sh;
        longint       t;
        bit           neg;
        sh  = (128'(coef) * 128'(mag(val))) >> 16;
        neg = (val < 0) ^ negate;
        if (neg) t = (sh > 128'h8000_0000_0000) ? longint'(S48_MIN) : -longint'(sh[63:0]);
        else     t = (sh > 128'h7FFF_FFFF_FFFF) ? longint'(S48_MAX) : longint'(sh[63:0]);
        return sat48(acc + t);
    endfunction

    function automatic logic signed [31:0] accel_of(input longint f, input logic [31:0] m);
        logic [63:0]  fm;
        logic [127:0] q;
        fm = mag(f);
        if (fm == 0) return 32'sd0;
        q = (m == 0) ? (128'd1 << 40) : (128'(fm) << 16) / 128'(m);
        if (f < 0) return (q > 128'h8000_0000) ? 32'sh8000_0000 : 32'(-q);
        return (q > 128'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(q);
    endfunction

    // Advance the node state by one word; give the derivative after an up word
    task automatic predict_deriv(input word_t w, output bit has, output deriv_t d);
        longint      sx, sy, prx, pry;
        logic [63:0] len;
        has = 1'b0;
        d   = '{default: '0};
        if (w.mode == MODE_NODE) begin
            node_px = w.pos_x;  node_py = w.pos_y;
            node_vx = w.vel_x;  node_vy = w.vel_y;
            node_rx = w.rand_x; node_ry = w.rand_y;
            node_m  = w.mass;
            force_x = 0;
            force_y = 0;
        end else if (w.mode <= MODE_UP) begin
            sx  = (w.mode == MODE_RIGHT) ? longint'(w.pos_x) - node_px
                                         : node_px - longint'(w.pos_x);
            sy  = (w.mode == MODE_UP) ? longint'(w.pos_y) - node_py
                                      : node_py - longint'(w.pos_y);
            len = spring_len(mag(sx), mag(sy));
            prx = project(sx, len);
            pry = project(sy, len);

            if (w.mode == MODE_RIGHT)
                force_x = add_force(force_x, w.damping,
                                    longint'((mag(node_rx) * mag(node_vx)) >> 16), 1'b0);
            force_x = add_force(force_x, w.damping,
                                longint'(mag(node_vx - longint'(w.vel_x))), 1'b1);
            if (w.mode == MODE_RIGHT)     force_x = add_force(force_x, w.stiffness, prx, 1'b0);
            else if (w.mode == MODE_LEFT) force_x = add_force(force_x, w.stiffness, prx, 1'b1);
            else if (coupling)            force_x = add_force(force_x, w.stiffness, prx, 1'b1);

            if (w.mode == MODE_RIGHT)
                force_y = add_force(force_y, w.damping,
                                    longint'((mag(node_ry) * mag(node_vy)) >> 16), 1'b0);
            force_y = add_force(force_y, w.damping,
                                longint'(mag(node_vy - longint'(w.vel_y))), 1'b1);
            if (w.mode == MODE_UP)        force_y = add_force(force_y, w.stiffness, pry, 1'b0);
            else if (w.mode == MODE_DOWN) force_y = add_force(force_y, w.stiffness, pry, 1'b1);
            else if (coupling)            force_y = add_force(force_y, w.stiffness, pry, 1'b1);

            if (w.mode == MODE_UP) begin
                has = 1'b1;
                d.deriv_pos_x = node_vx[31:0];
                d.accel_x     = accel_of(force_x, node_m);
                d.deriv_pos_y = node_vy[31:0];
                d.accel_y     = accel_of(force_y, node_m);
            end
        end
    endtask

    function automatic bit idle_now();
        bit calm;
        calm = (cycle_cnt >= 60000) && (cycle_cnt < 90000);
        return !calm && ($urandom_range(99) < 36);
    endfunction

    // Offer one word, hold it until taken, then update the prediction
    task automatic send_word(input row_t r);
        bit     has;
        deriv_t d;
        i_in_valid  <= 1'b1;
        i_mode      <= r.w.mode;
        i_pos_x     <= r.w.pos_x;
        i_pos_y     <= r.w.pos_y;
        i_vel_x     <= r.w.vel_x;
        i_vel_y     <= r.w.vel_y;
        i_rand_x    <= r.w.rand_x;
        i_rand_y    <= r.w.rand_y;
        i_stiffness <= r.w.stiffness;
        i_damping   <= r.w.damping;
        i_mass      <= r.w.mass;
        do @(posedge i_clk); while (!o_in_ready);
        predict_deriv(r.w, has, d);
        if (has) deriv_q.push_back(r.fixed_exp ? r.d : d);
        if (idle_now()) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while (idle_now());
        end
    endtask

    task automatic write_coupling(input bit v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        coupling = v;
    endtask

    // Wait for every expected result, then let the last word finish its work
    task automatic drain();
        i_in_valid <= 1'b0;
        while (deriv_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick32();
        case ($urandom_range(9))
            0:       return 32'h0000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'hFFFF_FFFF;
            4, 5, 6: return 32'($urandom_range(0, 393216)) - 32'd196608;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_coef();
        return ($urandom_range(3) != 0) ? 32'($urandom_range(0, 196608)) : pick32();
    endfunction

    function automatic word_t rand_word(input logic [2:0] mode);
        word_t w;
        w.mode      = mode;
        w.pos_x     = pick32();
        w.pos_y     = pick32();
        w.vel_x     = pick32();
        w.vel_y     = pick32();
        w.rand_x    = pick32();
        w.rand_y    = pick32();
        w.stiffness = pick_coef();
        w.damping   = pick_coef();
        w.mass      = ($urandom_range(3) != 0) ? 32'($urandom_range(1, 262144)) : pick32();
        if (w.mass == 0) w.mass = MASS_ONE;
        return w;
    endfunction

    function automatic row_t mk_row(input word_t w);
        row_t r;
        r.w         = w;
        r.fixed_exp = 1'b0;
        r.d         = '{default: '0};
        return r;
    endfunction

    // Node word followed by right, left, down and up; neighbours mostly sit
    // within a couple of units of the node so the springs do real work
    task automatic send_group();
        word_t  nd;
        word_t  nb;
        nd = rand_word(MODE_NODE);
        send_word(mk_row(nd));
        for (int k = 1; k <= 4; k++) begin
            nb = rand_word(3'(k));
            if ($urandom_range(4) != 0) begin
                nb.pos_x = nd.pos_x + 32'($urandom_range(0, 262144)) - 32'd131072;
                nb.pos_y = nd.pos_y + 32'($urandom_range(0, 262144)) - 32'd131072;
            end
            send_word(mk_row(nb));
        end
    endtask

    task automatic build_directed();
        row_t r;
        word_t w;
        // up word straight after reset: zero node, zero sums, nothing moves
        w = '{mode: MODE_UP, mass: MASS_ONE, default: '0};
        r = mk_row(w);
        r.fixed_exp = 1'b1;
        r.d = '{default: '0};
        dir_rows.push_back(r);
        // unused modes are dropped
        w.mode = 3'd5; dir_rows.push_back(mk_row(w));
        w.mode = 3'd7; dir_rows.push_back(mk_row(w));
        // zero mass: accelerations saturate with the sign of the force
        w = '{mode: MODE_NODE, vel_x: 32'sh0001_0000, vel_y: -32'sh0001_0000, default: '0};
        dir_rows.push_back(mk_row(w));
        w = '{mode: MODE_UP, damping: 32'h0001_0000, default: '0};
        r = mk_row(w);
        r.fixed_exp = 1'b1;
        r.d = '{deriv_pos_x: 32'sh0001_0000, accel_x: 32'sh8000_0000,
                deriv_pos_y: -32'sh0001_0000, accel_y: 32'sh8000_0000};
        dir_rows.push_back(r);
        // extremes on every field for a full node
        w = '{mode: MODE_NODE, pos_x: 32'sh7FFF_FFFF, pos_y: 32'sh8000_0000,
              vel_x: 32'sh8000_0000, vel_y: 32'sh7FFF_FFFF, rand_x: 32'sh7FFF_FFFF,
              rand_y: 32'sh8000_0000, stiffness: '1, damping: '1, mass: 32'h0000_0001};
        dir_rows.push_back(mk_row(w));
        for (int k = 1; k <= 4; k++) begin
            w = '{mode: 3'(k), pos_x: 32'sh8000_0000, pos_y: 32'sh7FFF_FFFF,
                  vel_x: 32'sh7FFF_FFFF, vel_y: 32'sh8000_0000, rand_x: 32'sh8000_0000,
                  rand_y: 32'sh7FFF_FFFF, stiffness: '1, damping: '1, mass: '1};
            dir_rows.push_back(mk_row(w));
        end
        // stretched springs, largest mass; then a repeated up direction
        w = '{mode: MODE_NODE, mass: 32'hFFFF_FFFF, rand_x: 32'sh0002_0000,
              vel_x: 32'sh0000_8000, default: '0};
        dir_rows.push_back(mk_row(w));
        w = '{mode: MODE_RIGHT, pos_x: 32'sh0003_0000, stiffness: 32'h0001_0000,
              damping: 32'h0000_4000, default: '0};
        dir_rows.push_back(mk_row(w));
        w = '{mode: MODE_LEFT, pos_x: -32'sh0001_0000, pos_y: 32'sh0000_8000,
              stiffness: 32'h0002_0000, default: '0};
        dir_rows.push_back(mk_row(w));
        w = '{mode: MODE_DOWN, pos_y: -32'sh0002_0000, stiffness: 32'h0001_0000,
              default: '0};
        dir_rows.push_back(mk_row(w));
        w = '{mode: MODE_UP, pos_y: 32'sh0002_0000, stiffness: 32'h0001_0000, default: '0};
        dir_rows.push_back(mk_row(w));
        dir_rows.push_back(mk_row(w));
        // neighbour words with no node word in front, full range content
        for (int k = 1; k <= 4; k++) dir_rows.push_back(mk_row(rand_word(3'(k))));
    endtask

    // Receiver: random stalls, plus one long hold-off when asked
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end
            i_out_ready <= !idle_now();
        end
    end

    // Compare every result word with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (deriv_q.size() == 0) begin
                $error("unexpected result word: deriv_pos_x %h accel_x %h",
                       o_deriv_pos_x, o_accel_x);
                fails++;
            end else begin
                if (o_deriv_pos_x !== deriv_q[0].deriv_pos_x) begin
                    $error("deriv_pos_x: expected %h, got %h",
                           deriv_q[0].deriv_pos_x, o_deriv_pos_x);
                    fails++;
                end
                if (o_accel_x !== deriv_q[0].accel_x) begin
                    $error("accel_x: expected %h, got %h", deriv_q[0].accel_x, o_accel_x);
                    fails++;
                end
                if (o_deriv_pos_y !== deriv_q[0].deriv_pos_y) begin
                    $error("deriv_pos_y: expected %h, got %h",
                           deriv_q[0].deriv_pos_y, o_deriv_pos_y);
                    fails++;
                end
                if (o_accel_y !== deriv_q[0].accel_y) begin
                    $error("accel_y: expected %h, got %h", deriv_q[0].accel_y, o_accel_y);
                    fails++;
                end
                void'(deriv_q.pop_front());
            end
        end
    end

    // Watchdog: count cycles with no word moving on any channel
    initial begin
        int quiet;
        quiet = 0;
        cycle_cnt = 0;
        forever begin
            @(posedge i_clk);
            cycle_cnt++;
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("tb_lattice_node_spring_derivative_top: FAIL");
                $finish;
            end
        end
    end

    // Stimulus
    initial begin
        int sent;
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = 1'b0;
        i_in_valid  = 1'b0;
        i_mode      = MODE_NODE;
        i_pos_x     = '0;
        i_pos_y     = '0;
        i_vel_x     = '0;
        i_vel_y     = '0;
        i_rand_x    = '0;
        i_rand_y    = '0;
        i_stiffness = '0;
        i_damping   = '0;
        i_mass      = MASS_ONE;
        fails       = 0;
        hold_req    = 1'b0;
        // reset state of the node and the coupling
        node_px = 0; node_py = 0; node_vx = 0; node_vy = 0; node_rx = 0; node_ry = 0;
        node_m  = MASS_ONE;
        force_x = 0; force_y = 0;
        coupling = 1'b1;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        build_directed();
        foreach (dir_rows[i]) send_word(dir_rows[i]);
        drain();

        // random phases, coupling flipped between them
        for (int p = 0; p < 4; p++) begin
            write_coupling(p[0] == 1'b0 ? 1'b0 : 1'b1);
            if (p == 2) hold_req = 1'b1;
            sent = 0;
            while (sent < PHASE_WORDS) begin
                if ($urandom_range(9) == 0) begin
                    // noise: a lone word of any kind, unused modes included
                    send_word(mk_row(rand_word(3'($urandom_range(7)))));
                    sent++;
                end else begin
                    send_group();
                    sent += 5;
                end
            end
            drain();
        end

        if (fails == 0 && deriv_q.size() == 0) begin
            $display("tb_lattice_node_spring_derivative_top: PASS");
        end else begin
            $display("tb_lattice_node_spring_derivative_top: FAIL");
        end
        $finish;
    end

endmodule

FILE: lattice_node_spring_derivative_top.f
design/lnsd_pkg.sv
design/lnsd_divsqrt.sv
design/lattice_node_spring_derivative_top.sv
tb/tb_lattice_node_spring_derivative_top.sv
